@@ rtl/lsrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lsrs_pkg: shared types and constants for the light sensor readout sequencer
// Event and result word layouts, sequencer states, datapath command/status.
// ----------------------------------------------------------------------------
package lsrs_pkg;

	localparam int LUX_FRAC_BITS = 12;
	localparam int QUO_W = 32;
	localparam int CNT_W = $clog2(QUO_W);
	localparam int TG_W = 23;                 // time_ms * gain, max 600*9876
	localparam int DEN_W = 16 + TG_W;
	localparam int NUM_W = 32 + 9;            // d*d*408
	localparam int DIV_W = DEN_W + QUO_W;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 3;

	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_OK   = 2'd1;
	localparam logic [1:0] MODE_ERR  = 2'd2;
	localparam logic [1:0] MODE_REQ  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEG = 1'b1;

	localparam logic [7:0] CMD_BIT     = 8'hA0;
	localparam logic [4:0] REG_ENABLE  = 5'h00;
	localparam logic [4:0] REG_CONTROL = 5'h01;
	localparam logic [4:0] REG_STATUS  = 5'h13;
	localparam logic [4:0] REG_CH0     = 5'h14;
	localparam logic [7:0] EN_ON       = 8'h03;
	localparam logic [7:0] EN_OFF      = 8'h01;
	localparam logic [8:0] LUX_DF      = 9'd408;
	// ceil(2^38/5): x*M >> 38 is floor(x/5) for any x below 2^38
	localparam logic [35:0] DIV5_M     = 36'hC_CCCC_CCCD;

	typedef enum logic [3:0] {
		SQ_UNCONF, SQ_CONFIGURING, SQ_IDLE, SQ_REQUESTED, SQ_ENABLING, SQ_ENABLED,
		SQ_POLLING, SQ_DATA_READY, SQ_READING, SQ_RECEIVED, SQ_DIS_PEND, SQ_DISABLING
	} seq_t;

	typedef enum logic [3:0] {
		PH_IDLE, PH_EXEC, PH_MUL1, PH_MUL2, PH_DIVL_INIT, PH_DIVL, PH_SMOOTH,
		PH_DIVS, PH_FIN
	} ph_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        bus_idle;
		logic [31:0] read_data;
	} in_t;

	typedef struct packed {
		logic        issue;
		logic        is_read;
		logic [7:0]  command_byte;
		logic [7:0]  write_byte;
		logic [2:0]  byte_count;
		logic        request_accepted;
		logic        started;
		logic        ready_res;
		logic        result_valid;
		logic [15:0] full_count;
		logic [15:0] ir_count;
		logic [31:0] lux_smoothed;
	} out_t;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic cfg_we;
		logic mul1;
		logic mul2;
		logic lux_init;
		logic div_step;
		logic lux_store;
		logic smooth_init;
		logic smooth_store;
	} dp_cmd_t;

	typedef struct packed {
		logic deliver;
		logic lux_ok;
		logic sat;
		logic smooth_zero;
		logic div_last;
	} dp_sts_t;

	function automatic logic [TG_W-1:0] tg_lookup(input logic [1:0] g, input logic [2:0] t);
		logic [13:0] gv;
		logic [9:0]  tv;
		case (g)
			2'd0: gv = 14'd1;
			2'd1: gv = 14'd25;
			2'd2: gv = 14'd428;
			default: gv = 14'd9876;
		endcase
		case (t)
			3'd1: tv = 10'd200;
			3'd2: tv = 10'd300;
			3'd3: tv = 10'd400;
			3'd4: tv = 10'd500;
			3'd5: tv = 10'd600;
			default: tv = 10'd100;
		endcase
		return TG_W'(gv) * TG_W'(tv);
	endfunction

endpackage

@@ rtl/lsrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsrs_ctrl: phase controller
// Handshakes, result slot tracking and sequencing of the lux arithmetic.
// ----------------------------------------------------------------------------
module lsrs_ctrl import lsrs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ph_t  ph_q, ph_n;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			ph_q <= ph_n;
			if (cmd.exec)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		ph_n = ph_q;
		case (ph_q)
			PH_IDLE:      if (in_valid) ph_n = PH_EXEC;
			PH_EXEC: begin
				if (sts.deliver)
					ph_n = sts.lux_ok ? PH_MUL1 : PH_SMOOTH;
				else if (slot_free)
					ph_n = PH_IDLE;
			end
			PH_MUL1:      ph_n = PH_MUL2;
			PH_MUL2:      ph_n = PH_DIVL_INIT;
			PH_DIVL_INIT: ph_n = sts.sat ? PH_SMOOTH : PH_DIVL;
			PH_DIVL:      if (sts.div_last) ph_n = PH_SMOOTH;
			PH_SMOOTH:    ph_n = sts.smooth_zero ? PH_FIN : PH_DIVS;
			PH_DIVS:      ph_n = PH_FIN;
			PH_FIN:       if (slot_free) ph_n = PH_IDLE;
			default:      ph_n = PH_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		cmd.cfg_we = cfg_valid;
		case (ph_q)
			PH_IDLE: begin
				in_ready = 1'b1;
				cmd.load_in = in_valid;
			end
			PH_EXEC:      cmd.exec = !sts.deliver && slot_free;
			PH_MUL1:      cmd.mul1 = 1'b1;
			PH_MUL2:      cmd.mul2 = 1'b1;
			PH_DIVL_INIT: cmd.lux_init = 1'b1;
			PH_DIVL: begin
				cmd.div_step = 1'b1;
				cmd.lux_store = sts.div_last;
			end
			PH_SMOOTH:    cmd.smooth_init = 1'b1;
			PH_DIVS:      cmd.smooth_store = 1'b1;
			PH_FIN:       cmd.exec = slot_free;
			default: ;
		endcase
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ph_q == PH_EXEC)
		else $error("accepted word not executed");
	a_exec_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q)
		else $error("result word lost");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (!out_valid_q || out_ready))
		else $error("result word overwritten");

endmodule

@@ rtl/lsrs_dp.sv @@
// ----------------------------------------------------------------------------
// lsrs_dp: sequencer datapath
// Sensor sequencing state, result register, multipliers, lux divider, div-by-5.
// ----------------------------------------------------------------------------
module lsrs_dp import lsrs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	input  in_t                   in_data,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output out_t                  out_data
);

	logic [1:0]        gain_q;
	logic [2:0]        integ_q;
	seq_t              seq_q, seq_n;
	logic [4:0]        ptr_q, ptr_n;
	logic [15:0]       full_q, ir_q, full_n, ir_n;
	logic [31:0]       last_lux_q, smooth_q;
	in_t               in_q;
	out_t              res_q, r;
	logic [31:0]       dd_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DIV_W-1:0]  rem_q, dsh_q, numf, den_top;
	logic [QUO_W-1:0]  quo_q, quo_nxt;
	logic [CNT_W-1:0]  cnt_q;
	logic [15:0]       diff;
	logic [34:0]       s4;
	logic [52:0]       sm_lo_q, sm_hi;
	logic [70:0]       sm_prod;
	logic              ge;
	logic [4:0]        tgt;

	assign out_data = res_q;
	assign diff = (full_q > ir_q) ? full_q - ir_q : ir_q - full_q;
	assign numf = DIV_W'({num_q, {LUX_FRAC_BITS{1'b0}}});
	assign den_top = {den_q, {QUO_W{1'b0}}};
	assign ge = rem_q >= dsh_q;
	assign quo_nxt = {quo_q[QUO_W-2:0], ge};
	assign s4 = {1'b0, smooth_q, 2'b00} + 35'(last_lux_q);
	// s4 / 5 by reciprocal multiply, low half of the product registered first
	assign sm_hi = s4 * DIV5_M[35:18];
	assign sm_prod = {sm_hi, 18'd0} + 71'(sm_lo_q);
	assign tgt = (seq_q == SQ_ENABLED) ? REG_STATUS : REG_CH0;

	assign sts.deliver = in_q.mode == MODE_TICK && seq_q == SQ_RECEIVED;
	assign sts.lux_ok = full_q != '0 && ir_q != '0;
	assign sts.sat = numf >= den_top;
	assign sts.smooth_zero = smooth_q == '0;
	assign sts.div_last = cnt_q == '0;

	// event decode
	always_comb begin
		r = '0;
		seq_n = seq_q;
		ptr_n = ptr_q;
		full_n = full_q;
		ir_n = ir_q;
		case (in_q.mode)
			MODE_TICK: begin
				case (seq_q)
					SQ_UNCONF: if (in_q.bus_idle) begin
						r.issue = 1'b1;
						r.command_byte = CMD_BIT | 8'(REG_CONTROL);
						r.write_byte = {2'b00, gain_q, 1'b0, integ_q};
						r.byte_count = 3'd1;
						ptr_n = REG_CONTROL;
						seq_n = SQ_CONFIGURING;
					end
					SQ_REQUESTED: if (in_q.bus_idle) begin
						r.issue = 1'b1;
						r.command_byte = CMD_BIT | 8'(REG_ENABLE);
						r.write_byte = EN_ON;
						r.byte_count = 3'd1;
						ptr_n = REG_ENABLE;
						seq_n = SQ_ENABLING;
					end
					SQ_ENABLED, SQ_DATA_READY: if (in_q.bus_idle) begin
						r.issue = 1'b1;
						r.command_byte = CMD_BIT | 8'(tgt);
						if (ptr_q == tgt) begin
							r.is_read = 1'b1;
							r.byte_count = (seq_q == SQ_ENABLED) ? 3'd1 : 3'd4;
							seq_n = (seq_q == SQ_ENABLED) ? SQ_POLLING : SQ_READING;
						end
					end
					SQ_RECEIVED: begin
						r.result_valid = 1'b1;
						r.full_count = full_q;
						r.ir_count = ir_q;
						r.lux_smoothed = smooth_q;
						seq_n = SQ_DIS_PEND;
					end
					SQ_DIS_PEND: if (in_q.bus_idle) begin
						r.issue = 1'b1;
						r.command_byte = CMD_BIT | 8'(REG_ENABLE);
						r.write_byte = EN_OFF;
						r.byte_count = 3'd1;
						ptr_n = REG_ENABLE;
						seq_n = SQ_DISABLING;
					end
					default: ;
				endcase
			end
			MODE_OK: begin
				case (seq_q)
					SQ_CONFIGURING: seq_n = SQ_IDLE;
					SQ_ENABLING:    seq_n = SQ_ENABLED;
					SQ_ENABLED:     ptr_n = REG_STATUS;
					SQ_POLLING:     seq_n = in_q.read_data[0] ? SQ_DATA_READY : SQ_ENABLED;
					SQ_DATA_READY:  ptr_n = REG_CH0;
					SQ_READING: begin
						full_n = in_q.read_data[15:0];
						ir_n = in_q.read_data[31:16];
						seq_n = SQ_RECEIVED;
					end
					SQ_DISABLING:   seq_n = SQ_IDLE;
					default: ;
				endcase
			end
			MODE_ERR: begin
				case (seq_q)
					SQ_CONFIGURING: seq_n = SQ_UNCONF;
					SQ_ENABLING:    seq_n = SQ_REQUESTED;
					SQ_POLLING:     seq_n = SQ_ENABLED;
					SQ_READING:     seq_n = SQ_DATA_READY;
					SQ_DISABLING:   seq_n = SQ_DIS_PEND;
					default: ;
				endcase
			end
			default: begin
				if (seq_q == SQ_IDLE) begin
					seq_n = SQ_REQUESTED;
					r.request_accepted = 1'b1;
				end
			end
		endcase
		r.started = seq_n != SQ_UNCONF && seq_n != SQ_CONFIGURING;
		r.ready_res = seq_n == SQ_IDLE;
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 2'd3;
			integ_q <= 3'd5;
			seq_q <= SQ_UNCONF;
			ptr_q <= '0;
			full_q <= '0;
			ir_q <= '0;
			last_lux_q <= '0;
			smooth_q <= '0;
		end else begin
			if (cmd.cfg_we) begin
				if (cfg_index == CFG_GAIN)
					gain_q <= cfg_data[1:0];
				else
					integ_q <= cfg_data;
				seq_q <= SQ_UNCONF;
			end else if (cmd.exec) begin
				seq_q <= seq_n;
			end
			if (cmd.exec) begin
				ptr_q <= ptr_n;
				full_q <= full_n;
				ir_q <= ir_n;
			end
			if (cmd.lux_init && sts.sat)
				last_lux_q <= '1;
			else if (cmd.lux_store)
				last_lux_q <= quo_nxt;
			if (cmd.smooth_init && sts.smooth_zero)
				smooth_q <= last_lux_q;
			else if (cmd.smooth_store)
				smooth_q <= sm_prod[69:38];
		end
	end

	// payload and arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.load_in)
			in_q <= in_data;
		if (cmd.exec)
			res_q <= r;
		if (cmd.mul1)
			dd_q <= diff * diff;
		if (cmd.mul2) begin
			num_q <= dd_q * LUX_DF;
			den_q <= full_q * tg_lookup(gain_q, integ_q);
		end
		if (cmd.smooth_init)
			sm_lo_q <= s4 * DIV5_M[17:0];
		if (cmd.lux_init) begin
			rem_q <= numf;
			dsh_q <= DIV_W'({den_q, {(QUO_W-1){1'b0}}});
			cnt_q <= '1;
		end else if (cmd.div_step) begin
			if (ge)
				rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= quo_nxt;
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ rtl/light_sensor_readout_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// light_sensor_readout_sequencer_top: I2C light sensor readout sequencer
// Turns bus events into transfer commands and delivers smoothed lux results.
// ----------------------------------------------------------------------------
// Words are accepted and executed one at a time into the result word. Delivery
// tick: two multiply stages, a 32-step restoring divide, a 1/5 multiply for
// smoothing, input held meanwhile; no divide if lux saturates, no multiply or
// divide if a count is zero, no 1/5 multiply if smoothed was zero. A waiting
// result stalls only the next word's execute step, not its accept.
// arst_n clears the sequencer to not configured, gain 9876x, 600 ms.
module light_sensor_readout_sequencer_top import lsrs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// event channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_data,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_t                  out_data,
	// register writes: index 0 gain code, index 1 integration code
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// controller: handshakes and phase sequencing of the lux arithmetic
	lsrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: sensor state, event decode, multipliers and divider
	lsrs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

endmodule
